/* src/pitb_pkg.sv */
// Shared constants and types for the point-in-triangle barycentric test core.
package pitb_pkg;

    // Default coordinate width (signed Q8.16 at 24 bits).
    localparam int COORD_WIDTH_DEF = 24;

    // Fixed-point format: fraction bits and the value one.
    localparam int Q_FRAC = 16;
    localparam int Q_ONE  = 65536;

    // Bound register widths and reset values.
    localparam int LB_W     = 24;
    localparam int UB_W     = 23;
    localparam int LB_RESET = -66;
    localparam int UB_RESET = 66191;

    // Register port geometry.
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    // Width of one slice of the denominator in the bound scaling multiply.
    localparam int CHUNK_W = 32;

    // Number of register stages in the datapath.
    localparam int NUM_STAGES = 9;

    typedef enum logic
    {
        REG_LOWER = 1'b0,
        REG_UPPER = 1'b1
    } reg_idx_t;

endpackage

/* src/point_in_triangle_barycentric_test_core.sv */
// Nine register stages; an accepted word passes through them in order and then shows on out_valid.
// Throughput: one word per cycle while out_ready is high; the nine register stages each take a new
// word every cycle, and a stalled output only holds back the stages behind it, bubbles are squeezed out.
// The widest logic sits in the split 56x56-bit products of the dot products (stages 4 and 5).
// Reset (rst_n low, asynchronous) empties the pipeline and loads the bound registers
// with about -0.001 in signed Q8.16 and 1.01 in unsigned Q7.16.
module point_in_triangle_barycentric_test_core
    import pitb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic                          degenerate
);

    // Edge vector components; the lifted z of the point needs room for one plus 3 * 2^(COORD_WIDTH-1).
    localparam int EW   = ((COORD_WIDTH > 17) ? COORD_WIDTH : 17) + 3;
    localparam int PW   = 2 * EW;            // one component product
    localparam int DW   = PW + 2;            // dot product
    localparam int HL   = DW / 2;            // low slice of a dot product
    localparam int HH   = DW - HL;           // high (signed) slice of a dot product
    localparam int MW   = 2 * DW;            // product of two dot products
    localparam int NW   = MW + 1;            // denominator and numerators
    localparam int NCH  = (NW + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW = NCH * CHUNK_W;
    localparam int BPW  = LB_W + CHUNK_W + 1; // bound times one denominator slice
    localparam int LW   = NW + LB_W;          // scaled bounds and shifted numerators

    // Operand pairs of the six second-level products, by dot product index:
    // 0 = d00, 1 = d01, 2 = d02, 3 = d11, 4 = d12.
    // Products: d00*d11, d01*d01, d11*d02, d01*d12, d00*d12, d01*d02.
    localparam int PROD_A [6] = '{0, 1, 3, 1, 0, 1};
    localparam int PROD_B [6] = '{3, 1, 2, 4, 4, 2};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [LB_W-1:0] lower_bound_reg;
    logic [UB_W-1:0]        upper_bound_reg;
    reg_idx_t               reg_sel;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= LB_W'(LB_RESET);
            upper_bound_reg <= UB_W'(UB_RESET);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_LOWER: lower_bound_reg <= pwdata[LB_W-1:0];
                REG_UPPER: upper_bound_reg <= pwdata[UB_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LOWER: prdata = PDATA_W'(lower_bound_reg);
            REG_UPPER: prdata = PDATA_W'(upper_bound_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or its successor advances.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: edge vectors e0 = C - A, e1 = B - A, e2 = P - A
    // ------------------------------------------------------------------
    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e0_next [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];

    always_comb
    begin
        e0_next[0] = EW'(c_x) - EW'(a_x);
        e0_next[1] = EW'(c_y) - EW'(a_y);
        e0_next[2] = EW'(c_z) - EW'(a_z);
        e1_next[0] = EW'(b_x) - EW'(a_x);
        e1_next[1] = EW'(b_y) - EW'(a_y);
        e1_next[2] = EW'(b_z) - EW'(a_z);
        e2_next[0] = EW'(point_x) - EW'(a_x);
        e2_next[1] = EW'(point_y) - EW'(a_y);
        // The point's z is one minus x minus y.
        e2_next[2] = EW'(Q_ONE) - EW'(point_x) - EW'(point_y) - EW'(a_z);
    end

    // ------------------------------------------------------------------
    // Stage 2: the fifteen component products of the five dot products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] mul_reg [5][3];
    logic signed [PW-1:0] mul_next [5][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mul_next[0][k] = e0_reg[k] * e0_reg[k];
            mul_next[1][k] = e0_reg[k] * e1_reg[k];
            mul_next[2][k] = e0_reg[k] * e2_reg[k];
            mul_next[3][k] = e1_reg[k] * e1_reg[k];
            mul_next[4][k] = e1_reg[k] * e2_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dot products d00, d01, d02, d11, d12
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dot_reg [5];
    logic signed [DW-1:0] dot_next [5];

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dot_next[j] = DW'(mul_reg[j][0]) + DW'(mul_reg[j][1]) + DW'(mul_reg[j][2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of the six dot-product products.
    // Each operand splits into an unsigned low slice and a signed high slice.
    // ------------------------------------------------------------------
    logic [HL-1:0]           a_lo;
    logic [HL-1:0]           b_lo;
    logic signed [HH-1:0]    a_hi;
    logic signed [HH-1:0]    b_hi;
    logic [2*HL-1:0]         pll_reg [6];
    logic signed [HL+HH:0]   plh_reg [6];
    logic signed [HL+HH:0]   phl_reg [6];
    logic signed [2*HH-1:0]  phh_reg [6];
    logic [2*HL-1:0]         pll_next [6];
    logic signed [HL+HH:0]   plh_next [6];
    logic signed [HL+HH:0]   phl_next [6];
    logic signed [2*HH-1:0]  phh_next [6];

    always_comb
    begin
        a_lo = '0;
        b_lo = '0;
        a_hi = '0;
        b_hi = '0;
        for (int i = 0; i < 6; i++)
        begin
            a_lo = dot_reg[PROD_A[i]][HL-1:0];
            a_hi = dot_reg[PROD_A[i]][DW-1:HL];
            b_lo = dot_reg[PROD_B[i]][HL-1:0];
            b_hi = dot_reg[PROD_B[i]][DW-1:HL];
            pll_next[i] = a_lo * b_lo;
            plh_next[i] = $signed({1'b0, a_lo}) * b_hi;
            phl_next[i] = a_hi * $signed({1'b0, b_lo});
            phh_next[i] = a_hi * b_hi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the partial products
    // ------------------------------------------------------------------
    logic signed [MW-1:0] prod_reg [6];
    logic signed [MW-1:0] prod_next [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            prod_next[i] = MW'(pll_reg[i])
                         + (MW'(plh_reg[i]) << HL)
                         + (MW'(phl_reg[i]) << HL)
                         + (MW'(phh_reg[i]) << (2 * HL));
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: denominator and numerators
    // ------------------------------------------------------------------
    logic signed [NW-1:0] den_reg;
    logic signed [NW-1:0] nu_reg;
    logic signed [NW-1:0] nv_reg;
    logic signed [NW-1:0] den_next;
    logic signed [NW-1:0] nu_next;
    logic signed [NW-1:0] nv_next;

    always_comb
    begin
        den_next = NW'(prod_reg[0]) - NW'(prod_reg[1]);
        nu_next  = NW'(prod_reg[2]) - NW'(prod_reg[3]);
        nv_next  = NW'(prod_reg[4]) - NW'(prod_reg[5]);
    end

    // ------------------------------------------------------------------
    // Stage 7: bounds times denominator slice by slice, numerator sum,
    // degenerate flag. The denominator is a Gram determinant and never negative,
    // so its slices are all unsigned.
    // ------------------------------------------------------------------
    logic [PADW-1:0]         den_pad;
    logic [CHUNK_W-1:0]      den_chunk;
    logic signed [LB_W-1:0]  ub_mul;
    logic signed [BPW-1:0]   lop_reg [NCH];
    logic signed [BPW-1:0]   hip_reg [NCH];
    logic signed [BPW-1:0]   lop_next [NCH];
    logic signed [BPW-1:0]   hip_next [NCH];
    logic signed [NW-1:0]    nu7_reg;
    logic signed [NW-1:0]    nv7_reg;
    logic signed [NW:0]      sum7_reg;
    logic signed [NW:0]      sum7_next;
    logic                    zero7_reg;
    logic                    zero7_next;

    always_comb
    begin
        den_pad   = PADW'(den_reg);
        ub_mul    = $signed({1'b0, upper_bound_reg});
        den_chunk = '0;
        for (int c = 0; c < NCH; c++)
        begin
            den_chunk   = den_pad[c*CHUNK_W +: CHUNK_W];
            lop_next[c] = lower_bound_reg * $signed({1'b0, den_chunk});
            hip_next[c] = ub_mul * $signed({1'b0, den_chunk});
        end
        sum7_next  = (NW+1)'(nu_reg) + (NW+1)'(nv_reg);
        zero7_next = (den_reg == '0);
    end

    // ------------------------------------------------------------------
    // Stage 8: assemble the scaled bounds
    // ------------------------------------------------------------------
    logic signed [LW-1:0] lo_reg;
    logic signed [LW-1:0] hi_reg;
    logic signed [LW-1:0] lo_next;
    logic signed [LW-1:0] hi_next;
    logic signed [NW-1:0] nu8_reg;
    logic signed [NW-1:0] nv8_reg;
    logic signed [NW:0]   sum8_reg;
    logic                 zero8_reg;

    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int c = 0; c < NCH; c++)
        begin
            lo_next = lo_next + (LW'(lop_reg[c]) <<< (c * CHUNK_W));
            hi_next = hi_next + (LW'(hip_reg[c]) <<< (c * CHUNK_W));
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: compare the numerators, scaled by one, against the scaled bounds
    // ------------------------------------------------------------------
    logic signed [LW-1:0] nu_sh;
    logic signed [LW-1:0] nv_sh;
    logic signed [LW-1:0] sum_sh;
    logic                 inside_res_reg;
    logic                 inside_res_next;
    logic                 degenerate_reg;
    logic                 degenerate_next;

    always_comb
    begin
        nu_sh  = LW'(nu8_reg) <<< Q_FRAC;
        nv_sh  = LW'(nv8_reg) <<< Q_FRAC;
        sum_sh = LW'(sum8_reg) <<< Q_FRAC;
        inside_res_next = !zero8_reg
                       && (nu_sh >= lo_reg) && (nu_sh <= hi_reg)
                       && (nv_sh >= lo_reg) && (nv_sh <= hi_reg)
                       && (sum_sh <= hi_reg);
        degenerate_next = zero8_reg;
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
        if (adv[1])
        begin
            mul_reg <= mul_next;
        end
        if (adv[2])
        begin
            dot_reg <= dot_next;
        end
        if (adv[3])
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
        end
        if (adv[4])
        begin
            prod_reg <= prod_next;
        end
        if (adv[5])
        begin
            den_reg <= den_next;
            nu_reg  <= nu_next;
            nv_reg  <= nv_next;
        end
        if (adv[6])
        begin
            lop_reg   <= lop_next;
            hip_reg   <= hip_next;
            nu7_reg   <= nu_reg;
            nv7_reg   <= nv_reg;
            sum7_reg  <= sum7_next;
            zero7_reg <= zero7_next;
        end
        if (adv[7])
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            nu8_reg   <= nu7_reg;
            nv8_reg   <= nv7_reg;
            sum8_reg  <= sum7_reg;
            zero8_reg <= zero7_reg;
        end
        if (adv[8])
        begin
            inside_res_reg <= inside_res_next;
            degenerate_reg <= degenerate_next;
        end
    end

    assign inside_res = inside_res_reg;
    assign degenerate = degenerate_reg;

`ifndef ASSERT_OFF
    // A degenerate triangle never reports the point as inside.
    a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !inside_res)
        else $error("degenerate word reported as inside");

    // The input side only stalls when every stage holds a word.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg))
        else $error("input stalled while the pipeline has a bubble");

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted word lost at stage one");

    // A stalled output stage keeps its word until it is taken.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NUM_STAGES-1] && !out_ready |=> vld_reg[NUM_STAGES-1])
        else $error("output word dropped while stalled");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for the barycentric point-in-triangle core: scoreboard, stimulus and checking.
`timescale 1ns / 100ps

module tb_top;
    import pitb_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam int CMAX         = 8388607;
    localparam int CMIN         = -8388608;
    localparam int HOLD_CYCLES  = 90;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [255:0]       big_t;

    typedef struct {
        coord_t a_x, a_y, a_z;
        coord_t b_x, b_y, b_z;
        coord_t c_x, c_y, c_z;
        coord_t point_x, point_y;
    } query_t;

    typedef struct {
        logic in_tri;
        logic degen;
    } verdict_t;

    class inclusion_board;
        verdict_t               pending_verdicts[$];
        logic signed [LB_W-1:0] lower_q;
        logic [UB_W-1:0]        upper_q;
        int                     errors;
        int                     checked;
        int                     inside_seen;
        int                     degen_seen;

        function new();
            lower_q     = LB_RESET;
            upper_q     = UB_RESET;
            errors      = 0;
            checked     = 0;
            inside_seen = 0;
            degen_seen  = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
            if (idx == REG_LOWER)
                lower_q = data[LB_W-1:0];
            else
                upper_q = data[UB_W-1:0];
        endfunction

        static function big_t dot3(big_t x0, big_t x1, big_t x2, big_t y0, big_t y1, big_t y2);
            return x0 * y0 + x1 * y1 + x2 * y2;
        endfunction

        // Exact integer test; the denominator is a Gram determinant and never negative,
        // so u and v are compared as numerator * one against bound * denominator.
        function verdict_t classify_point(query_t q);
            verdict_t r;
            big_t     pz, e0x, e0y, e0z, e1x, e1y, e1z, e2x, e2y, e2z;
            big_t     d00, d01, d02, d11, d12, den, nu, nv, lo, hi, lo_b, hi_b;
            pz  = big_t'(Q_ONE) - big_t'(q.point_x) - big_t'(q.point_y);
            e0x = big_t'(q.c_x) - big_t'(q.a_x);
            e0y = big_t'(q.c_y) - big_t'(q.a_y);
            e0z = big_t'(q.c_z) - big_t'(q.a_z);
            e1x = big_t'(q.b_x) - big_t'(q.a_x);
            e1y = big_t'(q.b_y) - big_t'(q.a_y);
            e1z = big_t'(q.b_z) - big_t'(q.a_z);
            e2x = big_t'(q.point_x) - big_t'(q.a_x);
            e2y = big_t'(q.point_y) - big_t'(q.a_y);
            e2z = pz - big_t'(q.a_z);
            d00 = dot3(e0x, e0y, e0z, e0x, e0y, e0z);
            d01 = dot3(e0x, e0y, e0z, e1x, e1y, e1z);
            d02 = dot3(e0x, e0y, e0z, e2x, e2y, e2z);
            d11 = dot3(e1x, e1y, e1z, e1x, e1y, e1z);
            d12 = dot3(e1x, e1y, e1z, e2x, e2y, e2z);
            den = d00 * d11 - d01 * d01;
            if (den == 0)
            begin
                r.in_tri = 1'b0;
                r.degen  = 1'b1;
                return r;
            end
            nu   = (d11 * d02 - d01 * d12) <<< Q_FRAC;
            nv   = (d00 * d12 - d01 * d02) <<< Q_FRAC;
            lo_b = lower_q;
            hi_b = {{(256-UB_W){1'b0}}, upper_q};
            lo   = lo_b * den;
            hi   = hi_b * den;
            r.in_tri = (nu >= lo) && (nu <= hi) && (nv >= lo) && (nv <= hi) && (nu + nv <= hi);
            r.degen  = 1'b0;
            return r;
        endfunction

        function void note_query(query_t q);
            pending_verdicts.insert(pending_verdicts.size(), classify_point(q));
        endfunction

        function void check_verdict(logic in_tri, logic degen);
            verdict_t exp_v;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result word, inside_res %0b degenerate %0b",
                         $time, in_tri, degen);
                errors++;
                return;
            end
            exp_v = pending_verdicts.pop_front();
            checked++;
            if (in_tri === 1'b1)
                inside_seen++;
            if (degen === 1'b1)
                degen_seen++;
            if (in_tri !== exp_v.in_tri)
            begin
                $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                         $time, exp_v.in_tri, in_tri);
                errors++;
            end
            if (degen !== exp_v.degen)
            begin
                $display("%0t: degenerate mismatch, expected %0b, actual %0b",
                         $time, exp_v.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    coord_t              a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y;
    logic                out_valid;
    logic                out_ready;
    logic                inside_res;
    logic                degenerate;

    inclusion_board board;
    bit             calm;
    bit             hold_request;
    int             sent_count;
    int             settings_count;

    point_in_triangle_barycentric_test_core #(
        .COORD_WIDTH(COORD_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inside_res(inside_res),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout at %0t with %0d results outstanding", $time,
                 board.pending_verdicts.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result monitor: outputs are sampled at the edge, before any update.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_verdict(inside_res, degenerate);
    end

    // Receiver: random back-pressure bursts, plus one long hold on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic query_t mk_query(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int px, int py);
        query_t q;
        q.a_x = coord_t'(ax);
        q.a_y = coord_t'(ay);
        q.a_z = coord_t'(az);
        q.b_x = coord_t'(bx);
        q.b_y = coord_t'(by);
        q.b_z = coord_t'(bz);
        q.c_x = coord_t'(cx);
        q.c_y = coord_t'(cy);
        q.c_z = coord_t'(cz);
        q.point_x = coord_t'(px);
        q.point_y = coord_t'(py);
        return q;
    endfunction

    function automatic int spread(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic query_t random_query();
        int     kind, span, ax, ay, bx, by, cx, cy, px, py, k;
        longint u, v;
        query_t q;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       span = 1 << 10;
            1, 2:    span = 1 << 17;
            default: span = 1 << 20;
        endcase
        if (kind < 60)
        begin
            // Vertices on the plane x + y + z = 1, where the lifted point also lies.
            ax = spread(span);
            ay = spread(span);
            bx = spread(span);
            by = spread(span);
            cx = spread(span);
            cy = spread(span);
            if ($urandom_range(0, 2) != 0)
            begin
                u  = longint'($urandom_range(0, 78643)) - 6554;
                v  = longint'($urandom_range(0, 78643)) - 6554;
                px = ax + int'((u * (cx - ax) + v * (bx - ax)) >>> Q_FRAC);
                py = ay + int'((u * (cy - ay) + v * (by - ay)) >>> Q_FRAC);
            end
            else
            begin
                px = ax + spread(span);
                py = ay + spread(span);
            end
            q = mk_query(ax, ay, Q_ONE - ax - ay, bx, by, Q_ONE - bx - by,
                         cx, cy, Q_ONE - cx - cy, px, py);
        end
        else if (kind < 75)
            q = mk_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (kind < 85)
        begin
            // Collinear or coincident vertices.
            ax = spread(span);
            ay = spread(span);
            bx = spread(span);
            by = spread(span);
            k  = int'($urandom_range(0, 3)) - 1;
            px = spread(span);
            py = spread(span);
            q = mk_query(ax, ay, ax - ay, bx, by, bx - by,
                         ax + k * (bx - ax), ay + k * (by - ay),
                         (ax - ay) + k * ((bx - by) - (ax - ay)), px, py);
        end
        else
            q = mk_query(spread(span), spread(span), spread(span), spread(span),
                         spread(span), spread(span), spread(span), spread(span),
                         spread(span), spread(span), spread(span));
        return q;
    endfunction

    task automatic send_query(input query_t q, input bit may_idle);
        in_valid <= 1'b1;
        a_x      <= q.a_x;
        a_y      <= q.a_y;
        a_z      <= q.a_z;
        b_x      <= q.b_x;
        b_y      <= q.b_y;
        b_z      <= q.b_z;
        c_x      <= q.c_x;
        c_y      <= q.c_y;
        c_z      <= q.c_z;
        point_x  <= q.point_x;
        point_y  <= q.point_y;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_query(q);
        sent_count++;
        if (may_idle && !calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, data);
    endtask

    task automatic set_bounds(input int lower, input int upper);
        logic [LB_W-1:0] lo_bits;
        logic [UB_W-1:0] up_bits;
        lo_bits = lower[LB_W-1:0];
        up_bits = upper[UB_W-1:0];
        reg_write(REG_LOWER, {{(PDATA_W-LB_W){1'b0}}, lo_bits});
        reg_write(REG_UPPER, {{(PDATA_W-UB_W){1'b0}}, up_bits});
        settings_count++;
    endtask

    task automatic run_random(input int n, input bit may_idle);
        for (int i = 0; i < n; i++)
            send_query(random_query(), may_idle);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic run_directed();
        query_t dq[$];
        // Unit triangle A = x axis, B = y axis, C = z axis: u = 1 - x - y, v = y.
        dq = {dq, mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        dq = {dq, mk_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                           CMAX, CMAX)};
        dq = {dq, mk_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX,
                           CMIN, CMAX)};
        dq = {dq, mk_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN,
                           CMAX, CMIN)};
        dq = {dq, mk_query(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX,
                           CMIN, CMIN)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 21845, 21845)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 0)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, Q_ONE, 0)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, Q_ONE)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 32768, -33)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 32768, -66)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 32768, -67)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, -655, 32768)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, -656, 32768)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, -600, 66191)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, -600, 66192)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 131072, 131072)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, CMIN, CMIN)};
        dq = {dq, mk_query(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, CMAX, CMAX)};
        // Collinear vertices and a permuted vertex order.
        dq = {dq, mk_query(0, 0, 0, Q_ONE, Q_ONE, 0, 131072, 131072, 0, 16384, 16384)};
        dq = {dq, mk_query(0, 0, Q_ONE, Q_ONE, 0, 0, 0, Q_ONE, 0, 16384, 16384)};
        // Triangle off the lifted plane; the point is projected onto it.
        dq = {dq, mk_query(0, 0, 0, 131072, 0, 0, 0, 131072, 0, 32768, 32768)};
        foreach (dq[i])
            send_query(dq[i], 1'b1);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        board          = new();
        calm           = 1'b0;
        hold_request   = 1'b0;
        sent_count     = 0;
        settings_count = 1;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        a_x      <= '0;
        a_y      <= '0;
        a_z      <= '0;
        b_x      <= '0;
        b_y      <= '0;
        b_z      <= '0;
        c_x      <= '0;
        c_y      <= '0;
        c_z      <= '0;
        point_x  <= '0;
        point_y  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(80, 1'b1);

        set_bounds(CMIN, CMAX);
        run_random(80, 1'b1);

        // Exact bounds; the receiver holds off long enough for the input to stall.
        set_bounds(0, Q_ONE);
        hold_request = 1'b1;
        run_random(85, 1'b0);

        set_bounds(-int'($urandom_range(0, 6554)), Q_ONE + int'($urandom_range(0, 6554)));
        run_random(80, 1'b1);

        // Positive lower bound above a zero upper bound.
        set_bounds(CMAX, 0);
        run_random(60, 1'b1);

        calm = 1'b1;
        set_bounds(LB_RESET, UB_RESET);
        run_random(90, 1'b1);

        repeat (NUM_STAGES + 4) @(posedge clk);
        if (board.pending_verdicts.size() != 0)
            $display("%0d expected results never arrived", board.pending_verdicts.size());
        $display("Checked %0d of %0d queries under %0d bound settings, with a long output hold.",
                 board.checked, sent_count, settings_count);
        $display("Results: %0d inside, %0d degenerate, %0d mismatches.",
                 board.inside_seen, board.degen_seen, board.errors);
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
